[rtl/core/brr_pkg.sv]
// Package for the BRR ADPCM decoder: widths, header codes, clamp limits and
// the header word shared by the top level and the predictor.
// Depends on nothing.
package brr_pkg;

	localparam int BYTE_W   = 8;
	localparam int POS_W    = 4;
	localparam int RANGE_W  = 4;
	localparam int HIST_W   = 15;
	localparam int SAMPLE_W = 16;
	localparam int ACC_W    = 20;

	localparam logic [POS_W-1:0]   BLOCK_DATA_BYTES = 4'd8;
	localparam logic [RANGE_W-1:0] RANGE_MAX        = 4'hC;

	localparam logic signed [ACC_W-1:0] CLAMP_HI  = 20'sd32767;
	localparam logic signed [ACC_W-1:0] CLAMP_LO  = -20'sd32768;
	localparam logic signed [ACC_W-1:0] FORCE_NEG = -20'sd2048;

	typedef enum logic [1:0] {
		FILTER_NONE = 2'd0,
		FILTER_ONE  = 2'd1,
		FILTER_TWO  = 2'd2,
		FILTER_THREE = 2'd3
	} filter_t;

	typedef struct packed {
		filter_t             filter;
		logic [RANGE_W-1:0]  shift_range;
	} brr_hdr_t;

endpackage

[rtl/core/brr_predict.sv]
// Nibble decode for one BRR sample: scale by range, add filter prediction,
// clamp to 16 bits and wrap to 15 bits. Uses brr_pkg.
module brr_predict (
	input  brr_pkg::brr_hdr_t                  hdr,
	input  logic [3:0]                         nibble,
	input  logic signed [brr_pkg::HIST_W-1:0]  hist_one,
	input  logic signed [brr_pkg::HIST_W-1:0]  hist_two,
	output logic signed [brr_pkg::HIST_W-1:0]  next_hist
);
	import brr_pkg::*;

	logic signed [3:0]       n;
	logic signed [ACC_W-1:0] nx;
	logic signed [ACC_W-1:0] scaled;
	logic signed [ACC_W-1:0] s1;
	logic signed [ACC_W-1:0] s2;
	logic signed [ACC_W-1:0] s1_x3;
	logic signed [ACC_W-1:0] s1_x13;
	logic signed [ACC_W-1:0] s2_x3;
	logic signed [ACC_W-1:0] pred;
	logic signed [ACC_W-1:0] acc;
	logic [SAMPLE_W-1:0]     clamped;

	assign n      = nibble;
	assign nx     = ACC_W'(n);
	assign s1     = ACC_W'(hist_one);
	assign s2     = ACC_W'(hist_two);
	assign s1_x3  = (s1 <<< 1) + s1;
	assign s1_x13 = (s1 <<< 3) + (s1 <<< 2) + s1;
	assign s2_x3  = (s2 <<< 1) + s2;

	always_comb begin
		if (hdr.shift_range <= RANGE_MAX) begin
			scaled = (nx <<< hdr.shift_range) >>> 1;
		end else begin
			scaled = n[3] ? FORCE_NEG : '0;
		end
	end

	always_comb begin
		case (hdr.filter)
			FILTER_NONE:  pred = '0;
			FILTER_ONE:   pred = s1 + ((-s1) >>> 4);
			FILTER_TWO:   pred = (s1 <<< 1) + ((-s1_x3) >>> 5) - s2 + (s2 >>> 4);
			FILTER_THREE: pred = (s1 <<< 1) + ((-s1_x13) >>> 6) - s2 + (s2_x3 >>> 4);
			default:      pred = '0;
		endcase
	end

	assign acc = scaled + pred;

	always_comb begin
		if (acc > CLAMP_HI) begin
			clamped = CLAMP_HI[SAMPLE_W-1:0];
		end else if (acc < CLAMP_LO) begin
			clamped = CLAMP_LO[SAMPLE_W-1:0];
		end else begin
			clamped = acc[SAMPLE_W-1:0];
		end
	end

	assign next_hist = clamped[HIST_W-1:0];

endmodule

[rtl/core/brr_adpcm_decoder.sv]
// BRR ADPCM decoder top level: byte intake, block tracking, nibble sequencing
// and output register. Uses brr_pkg and brr_predict.
// Each data byte is held in a work register and its two nibbles are evaluated
// one after the other through the one predictor, high nibble first, each
// result going to the output register. A new byte, data or header, is taken
// at the earliest while the held byte's second sample is being emitted.
// Reset clears block position, header fields, history and the finished flag.
module brr_adpcm_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                data_valid,
	output logic                                data_stall,
	input  logic [brr_pkg::BYTE_W-1:0]          data_byte,
	input  logic                                start_of_stream,
	output logic                                sample_valid,
	input  logic                                sample_stall,
	output logic signed [brr_pkg::SAMPLE_W-1:0] sample,
	output logic                                run_last,
	output logic                                stream_end,
	output logic                                loop_flag
);
	import brr_pkg::*;

	logic                     acc_in;
	logic                     out_free;
	logic                     emit;
	logic                     ignore;
	logic                     is_hdr;
	logic                     blk_last;
	logic [POS_W-1:0]         eff_pos;
	logic [3:0]               nibble;
	logic signed [HIST_W-1:0] next_hist;

	logic [POS_W-1:0]         pos_q;
	brr_hdr_t                 hdr_q;
	logic                     end_q;
	logic                     loop_q;
	logic                     finished_q;
	logic signed [HIST_W-1:0] hist_one_q;
	logic signed [HIST_W-1:0] hist_two_q;

	logic                     work_valid_q;
	logic                     work_low_q;
	logic [BYTE_W-1:0]        work_byte_q;
	logic                     work_last_q;
	logic                     work_loop_q;

	assign out_free   = !sample_valid || !sample_stall;
	assign emit       = work_valid_q && out_free;
	assign data_stall = work_valid_q && !(work_low_q && out_free);
	assign acc_in     = data_valid && !data_stall;

	assign eff_pos  = start_of_stream ? '0 : pos_q;
	assign ignore   = !start_of_stream && finished_q;
	assign is_hdr   = (eff_pos == '0) || (eff_pos > BLOCK_DATA_BYTES);
	assign blk_last = (eff_pos == BLOCK_DATA_BYTES) && end_q;
	assign nibble   = work_low_q ? work_byte_q[3:0] : work_byte_q[7:4];

	brr_predict u_predict (
		.hdr       (hdr_q),
		.nibble    (nibble),
		.hist_one  (hist_one_q),
		.hist_two  (hist_two_q),
		.next_hist (next_hist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			hdr_q      <= '{filter: FILTER_NONE, shift_range: '0};
			end_q      <= 1'b0;
			loop_q     <= 1'b0;
			finished_q <= 1'b0;
			hist_one_q <= '0;
			hist_two_q <= '0;
		end else begin
			if (acc_in && start_of_stream) begin
				hist_one_q <= '0;
				hist_two_q <= '0;
				finished_q <= 1'b0;
			end else if (emit) begin
				hist_two_q <= hist_one_q;
				hist_one_q <= next_hist;
			end
			if (acc_in && !ignore) begin
				if (is_hdr) begin
					end_q       <= data_byte[0];
					loop_q      <= data_byte[1];
					hdr_q       <= '{filter: filter_t'(data_byte[3:2]),
						shift_range: data_byte[7:4]};
					pos_q       <= POS_W'(1);
				end else begin
					pos_q <= (eff_pos == BLOCK_DATA_BYTES) ? '0 : eff_pos + POS_W'(1);
					if (blk_last) begin
						finished_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q <= 1'b0;
			work_low_q   <= 1'b0;
		end else begin
			if (acc_in && !ignore && !is_hdr) begin
				work_valid_q <= 1'b1;
				work_low_q   <= 1'b0;
			end else if (emit) begin
				if (work_low_q) begin
					work_valid_q <= 1'b0;
				end else begin
					work_low_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in && !ignore && !is_hdr) begin
			work_byte_q <= data_byte;
			work_last_q <= blk_last;
			work_loop_q <= loop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (out_free) begin
			sample_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sample     <= {next_hist, 1'b0};
			run_last   <= work_low_q;
			stream_end <= work_low_q && work_last_q;
			loop_flag  <= work_low_q && work_last_q && work_loop_q;
		end
	end

	a_even_sample : assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid |-> !sample[0])
		else $error("odd sample value");

	a_end_on_second : assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && stream_end) |-> run_last)
		else $error("stream end on first sample of a byte");

	a_loop_with_end : assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && loop_flag) |-> stream_end)
		else $error("loop flag outside stream end");

	a_ignored_no_work : assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && finished_q && !start_of_stream) |=> !work_valid_q)
		else $error("work loaded after end of stream");

endmodule
